// ===== sv/ppdr_pkg.sv =====
`default_nettype none
package ppdr_pkg;

  localparam logic [1:0] REQ_IMU  = 2'd0;
  localparam logic [1:0] REQ_ENC  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam int IDX_W     = 5;
  localparam int SQ_TERMS  = 4;
  localparam int SQRT_BITS = 31;
  localparam int DIV_BITS  = 16;
  localparam int ATAN_N    = 30;

  localparam logic [30:0] INV_PI4_Q30 = 31'h517CC1B7;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [15:0] QUAT_ONE  = 16'sd16384;

  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] yaw_rate_in;
    logic signed [15:0] speed_in;
    logic [19:0]        elapsed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [15:0] speed_out;
    logic signed [15:0] yaw_rate_out;
    logic signed [15:0] orient_x;
    logic signed [15:0] orient_y;
    logic signed [15:0] orient_z;
    logic signed [15:0] orient_w;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_YAWP, OP_MUL_LO, OP_MUL_HI, OP_HEAD_UPD,
    OP_CORD_INIT, OP_CORD_STEP, OP_CORD_FIN, OP_X_UPD, OP_Y_UPD,
    OP_PUBLISH, OP_SQ_ACC, OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_INIT,
    OP_DIV_STEP, OP_QUAT_FIN
  } dp_op_e;

  typedef enum logic [1:0] {
    MSEL_HEAD, MSEL_X, MSEL_Y
  } mul_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_YAWP, ST_HMUL_LO, ST_HMUL_HI, ST_HUPD, ST_CINIT, ST_CSTEP,
    ST_CFIN, ST_XMUL_LO, ST_XMUL_HI, ST_XUPD, ST_YMUL_LO, ST_YMUL_HI,
    ST_YUPD, ST_PUB, ST_SQ, ST_SQRT_INIT, ST_SQRT, ST_DIV_INIT, ST_DIV,
    ST_QFIN
  } state_e;

  typedef struct packed {
    dp_op_e           op;
    mul_sel_e         msel;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       el_zero;
    logic       out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/ppdr_ctrl.sv =====
`default_nettype none
module ppdr_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ppdr_pkg::dp_status_t status_i,
  output ppdr_pkg::dp_cmd_t    cmd_o
);

  localparam logic [ppdr_pkg::IDX_W-1:0] CORD_LAST =
    ppdr_pkg::IDX_W'(CORDIC_STEPS - 1);
  localparam logic [ppdr_pkg::IDX_W-1:0] SQ_LAST =
    ppdr_pkg::IDX_W'(ppdr_pkg::SQ_TERMS - 1);
  localparam logic [ppdr_pkg::IDX_W-1:0] SQRT_LAST =
    ppdr_pkg::IDX_W'(ppdr_pkg::SQRT_BITS - 1);
  localparam logic [ppdr_pkg::IDX_W-1:0] DIV_LAST =
    ppdr_pkg::IDX_W'(ppdr_pkg::DIV_BITS - 1);

  ppdr_pkg::state_e state_q, state_d;
  logic [ppdr_pkg::IDX_W-1:0] cnt_q, cnt_d;
  logic accept;

  assign accept = in_valid_i && (state_q == ppdr_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppdr_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      ppdr_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (status_i.req_type == ppdr_pkg::REQ_IMU) begin
            state_d = ppdr_pkg::ST_SQ;
          end else if (status_i.req_type == ppdr_pkg::REQ_TICK &&
                       !status_i.el_zero) begin
            state_d = ppdr_pkg::ST_YAWP;
          end else begin
            state_d = ppdr_pkg::ST_IDLE;
          end
        end
      end
      ppdr_pkg::ST_YAWP:    state_d = ppdr_pkg::ST_HMUL_LO;
      ppdr_pkg::ST_HMUL_LO: state_d = ppdr_pkg::ST_HMUL_HI;
      ppdr_pkg::ST_HMUL_HI: state_d = ppdr_pkg::ST_HUPD;
      ppdr_pkg::ST_HUPD:    state_d = ppdr_pkg::ST_CINIT;
      ppdr_pkg::ST_CINIT:   state_d = ppdr_pkg::ST_CSTEP;
      ppdr_pkg::ST_CSTEP: begin
        if (cnt_q == CORD_LAST) begin
          state_d = ppdr_pkg::ST_CFIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ppdr_pkg::ST_CFIN:    state_d = ppdr_pkg::ST_XMUL_LO;
      ppdr_pkg::ST_XMUL_LO: state_d = ppdr_pkg::ST_XMUL_HI;
      ppdr_pkg::ST_XMUL_HI: state_d = ppdr_pkg::ST_XUPD;
      ppdr_pkg::ST_XUPD:    state_d = ppdr_pkg::ST_YMUL_LO;
      ppdr_pkg::ST_YMUL_LO: state_d = ppdr_pkg::ST_YMUL_HI;
      ppdr_pkg::ST_YMUL_HI: state_d = ppdr_pkg::ST_YUPD;
      ppdr_pkg::ST_YUPD:    state_d = ppdr_pkg::ST_PUB;
      ppdr_pkg::ST_PUB: begin
        if (!status_i.out_busy) state_d = ppdr_pkg::ST_IDLE;
      end
      ppdr_pkg::ST_SQ: begin
        if (cnt_q == SQ_LAST) begin
          state_d = ppdr_pkg::ST_SQRT_INIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ppdr_pkg::ST_SQRT_INIT: state_d = ppdr_pkg::ST_SQRT;
      ppdr_pkg::ST_SQRT: begin
        if (cnt_q == SQRT_LAST) begin
          state_d = ppdr_pkg::ST_DIV_INIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ppdr_pkg::ST_DIV_INIT: state_d = ppdr_pkg::ST_DIV;
      ppdr_pkg::ST_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = ppdr_pkg::ST_QFIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ppdr_pkg::ST_QFIN: state_d = ppdr_pkg::ST_IDLE;
      default:           state_d = ppdr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = ppdr_pkg::OP_NONE;
    cmd_o.msel = ppdr_pkg::MSEL_HEAD;
    cmd_o.idx  = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ppdr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) cmd_o.op = ppdr_pkg::OP_LOAD;
      end
      ppdr_pkg::ST_YAWP:    cmd_o.op = ppdr_pkg::OP_YAWP;
      ppdr_pkg::ST_HMUL_LO: cmd_o.op = ppdr_pkg::OP_MUL_LO;
      ppdr_pkg::ST_HMUL_HI: cmd_o.op = ppdr_pkg::OP_MUL_HI;
      ppdr_pkg::ST_HUPD:    cmd_o.op = ppdr_pkg::OP_HEAD_UPD;
      ppdr_pkg::ST_CINIT:   cmd_o.op = ppdr_pkg::OP_CORD_INIT;
      ppdr_pkg::ST_CSTEP:   cmd_o.op = ppdr_pkg::OP_CORD_STEP;
      ppdr_pkg::ST_CFIN:    cmd_o.op = ppdr_pkg::OP_CORD_FIN;
      ppdr_pkg::ST_XMUL_LO: begin
        cmd_o.op   = ppdr_pkg::OP_MUL_LO;
        cmd_o.msel = ppdr_pkg::MSEL_X;
      end
      ppdr_pkg::ST_XMUL_HI: begin
        cmd_o.op   = ppdr_pkg::OP_MUL_HI;
        cmd_o.msel = ppdr_pkg::MSEL_X;
      end
      ppdr_pkg::ST_XUPD:    cmd_o.op = ppdr_pkg::OP_X_UPD;
      ppdr_pkg::ST_YMUL_LO: begin
        cmd_o.op   = ppdr_pkg::OP_MUL_LO;
        cmd_o.msel = ppdr_pkg::MSEL_Y;
      end
      ppdr_pkg::ST_YMUL_HI: begin
        cmd_o.op   = ppdr_pkg::OP_MUL_HI;
        cmd_o.msel = ppdr_pkg::MSEL_Y;
      end
      ppdr_pkg::ST_YUPD:    cmd_o.op = ppdr_pkg::OP_Y_UPD;
      ppdr_pkg::ST_PUB: begin
        if (!status_i.out_busy) cmd_o.op = ppdr_pkg::OP_PUBLISH;
      end
      ppdr_pkg::ST_SQ:        cmd_o.op = ppdr_pkg::OP_SQ_ACC;
      ppdr_pkg::ST_SQRT_INIT: cmd_o.op = ppdr_pkg::OP_SQRT_INIT;
      ppdr_pkg::ST_SQRT:      cmd_o.op = ppdr_pkg::OP_SQRT_STEP;
      ppdr_pkg::ST_DIV_INIT:  cmd_o.op = ppdr_pkg::OP_DIV_INIT;
      ppdr_pkg::ST_DIV:       cmd_o.op = ppdr_pkg::OP_DIV_STEP;
      ppdr_pkg::ST_QFIN:      cmd_o.op = ppdr_pkg::OP_QUAT_FIN;
      default:                cmd_o.op = ppdr_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/ppdr_dp.sv =====
`default_nettype none
module ppdr_dp #(
  parameter int POS_FRAC_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ppdr_pkg::in_item_t   in_i,
  input  ppdr_pkg::dp_cmd_t    cmd_i,
  output ppdr_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ppdr_pkg::out_item_t  out_o
);

  localparam int SH = 28 - POS_FRAC_BITS;
  localparam logic signed [37:0] DP_RND = 38'sd1 <<< (SH - 1);
  localparam int DB = ppdr_pkg::DIV_BITS;
  localparam logic signed [40:0] SAT_MAX = 41'sd2147483647;
  localparam logic signed [40:0] SAT_MIN = -41'sd2147483648;
  localparam logic signed [69:0] RND30 = 70'sd1 <<< 29;

  // architectural state
  logic signed [31:0] x_acc_q, y_acc_q;
  logic [31:0]        yaw_acc_q;
  logic signed [15:0] held_speed_q, held_yaw_q;
  logic signed [15:0] held_quat_q [4];
  logic               out_valid_q;

  // working registers
  logic [19:0]        el_q;
  logic signed [15:0] raw_q [4];
  logic signed [35:0] p_q, dp_q;
  logic signed [69:0] acc_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [32:0] cz_q, c_q, s_q;
  logic               neg_q;
  logic [32:0]        sum_q;
  logic [61:0]        v_q;
  logic [32:0]        rem_q;
  logic [30:0]        root_q;
  logic [31:0]        drem_q [4];
  logic [DB-1:0]      dnum_q [4];
  logic [DB-1:0]      dquo_q [4];
  ppdr_pkg::out_item_t out_q;

  // small multiplier: held rate times elapsed
  logic signed [15:0] sm_a;
  logic signed [36:0] sm;
  logic signed [37:0] dpr;
  assign sm_a = (cmd_i.op == ppdr_pkg::OP_YAWP) ? held_yaw_q : held_speed_q;
  assign sm   = sm_a * $signed({1'b0, el_q});
  assign dpr  = (38'(sm) + DP_RND) >>> SH;

  // shared multiplier, 36 x 33 bits in two halves
  logic signed [35:0] ma;
  logic signed [32:0] mb;
  logic signed [18:0] ma_part;
  logic signed [51:0] prod;
  always_comb begin
    unique case (cmd_i.msel)
      ppdr_pkg::MSEL_HEAD: begin
        ma = p_q;
        mb = $signed({2'b00, ppdr_pkg::INV_PI4_Q30});
      end
      ppdr_pkg::MSEL_X: begin
        ma = dp_q;
        mb = c_q;
      end
      ppdr_pkg::MSEL_Y: begin
        ma = dp_q;
        mb = s_q;
      end
      default: begin
        ma = p_q;
        mb = c_q;
      end
    endcase
    // upper half carries the sign, lower half is unsigned
    ma_part = (cmd_i.op == ppdr_pkg::OP_MUL_HI) ? 19'($signed(ma[35:18]))
                                                : $signed({1'b0, ma[17:0]});
  end
  assign prod = ma_part * mb;

  logic signed [69:0] acc_rnd;
  logic signed [39:0] delta;
  logic signed [40:0] pos_sum;
  logic signed [31:0] pos_sat;
  assign acc_rnd = acc_q + RND30;
  assign delta   = 40'(acc_rnd >>> 30);
  always_comb begin
    pos_sum = 41'((cmd_i.op == ppdr_pkg::OP_X_UPD) ? x_acc_q : y_acc_q) + 41'(delta);
    priority if (pos_sum > SAT_MAX) pos_sat = SAT_MAX[31:0];
    else if (pos_sum < SAT_MIN) pos_sat = SAT_MIN[31:0];
    else pos_sat = pos_sum[31:0];
  end

  // heading fold into the right half plane
  logic signed [32:0] zfold;
  logic               zneg;
  always_comb begin
    zfold = 33'($signed(yaw_acc_q));
    zneg  = 1'b0;
    priority if (zfold > 33'sd1073741824) begin
      zfold = zfold - 33'sd2147483648;
      zneg  = 1'b1;
    end else if (zfold < -33'sd1073741824) begin
      zfold = zfold + 33'sd2147483648;
      zneg  = 1'b1;
    end
  end

  logic signed [32:0] atan_v;
  assign atan_v = $signed({1'b0, ppdr_pkg::ATAN_TAB[cmd_i.idx]});

  // quaternion helpers
  logic signed [15:0] sq_in;
  logic [31:0]        sq_out;
  assign sq_in  = raw_q[cmd_i.idx[1:0]];
  assign sq_out = 32'(sq_in * sq_in);

  logic [34:0] remx;
  logic [32:0] trial;
  assign remx  = {rem_q[32:0], v_q[61:60]};
  assign trial = {root_q, 2'b01};

  logic [15:0] qmag  [4];
  logic [43:0] qnum  [4];
  logic [32:0] dr    [4];
  logic [DB-1:0] qcl [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qmag[k] = raw_q[k][15] ? 16'(-raw_q[k]) : raw_q[k];
      qnum[k] = {qmag[k], 28'b0} + 44'(root_q >> 1);
      dr[k]   = {drem_q[k], dnum_q[k][DB-1]};
      qcl[k]  = (dquo_q[k] > DB'(16384)) ? DB'(16384) : dquo_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_acc_q        <= '0;
      y_acc_q        <= '0;
      yaw_acc_q      <= '0;
      held_speed_q   <= '0;
      held_yaw_q     <= '0;
      held_quat_q[0] <= '0;
      held_quat_q[1] <= '0;
      held_quat_q[2] <= '0;
      held_quat_q[3] <= ppdr_pkg::QUAT_ONE;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.op == ppdr_pkg::OP_PUBLISH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        ppdr_pkg::OP_LOAD: begin
          if (in_i.req_type == ppdr_pkg::REQ_IMU) held_yaw_q <= in_i.yaw_rate_in;
          if (in_i.req_type == ppdr_pkg::REQ_ENC) held_speed_q <= in_i.speed_in;
        end
        ppdr_pkg::OP_HEAD_UPD: yaw_acc_q <= yaw_acc_q + acc_rnd[61:30];
        ppdr_pkg::OP_X_UPD:    x_acc_q <= pos_sat;
        ppdr_pkg::OP_Y_UPD:    y_acc_q <= pos_sat;
        ppdr_pkg::OP_QUAT_FIN: begin
          for (int k = 0; k < 4; k++) begin
            if (sum_q == '0) begin
              held_quat_q[k] <= (k == 3) ? ppdr_pkg::QUAT_ONE : 16'sd0;
            end else begin
              held_quat_q[k] <= raw_q[k][15] ? 16'(-$signed({1'b0, qcl[k]}))
                                             : 16'($signed({1'b0, qcl[k]}));
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ppdr_pkg::OP_LOAD: begin
        el_q     <= in_i.elapsed;
        raw_q[0] <= in_i.quat_x;
        raw_q[1] <= in_i.quat_y;
        raw_q[2] <= in_i.quat_z;
        raw_q[3] <= in_i.quat_w;
        sum_q    <= '0;
      end
      ppdr_pkg::OP_YAWP:     p_q <= sm[35:0];
      ppdr_pkg::OP_MUL_LO:   acc_q <= 70'(prod);
      ppdr_pkg::OP_MUL_HI:   acc_q <= acc_q + (70'(prod) <<< 18);
      ppdr_pkg::OP_HEAD_UPD: dp_q <= dpr[35:0];
      ppdr_pkg::OP_CORD_INIT: begin
        cx_q  <= ppdr_pkg::CORDIC_X0;
        cy_q  <= '0;
        cz_q  <= zfold;
        neg_q <= zneg;
      end
      ppdr_pkg::OP_CORD_STEP: begin
        if (!cz_q[32]) begin
          cx_q <= cx_q - (cy_q >>> cmd_i.idx);
          cy_q <= cy_q + (cx_q >>> cmd_i.idx);
          cz_q <= cz_q - atan_v;
        end else begin
          cx_q <= cx_q + (cy_q >>> cmd_i.idx);
          cy_q <= cy_q - (cx_q >>> cmd_i.idx);
          cz_q <= cz_q + atan_v;
        end
      end
      ppdr_pkg::OP_CORD_FIN: begin
        c_q <= neg_q ? 33'(-cx_q) : 33'(cx_q);
        s_q <= neg_q ? 33'(-cy_q) : 33'(cy_q);
      end
      ppdr_pkg::OP_PUBLISH: begin
        out_q.pos_x        <= x_acc_q;
        out_q.pos_y        <= y_acc_q;
        out_q.heading      <= yaw_acc_q;
        out_q.speed_out    <= held_speed_q;
        out_q.yaw_rate_out <= held_yaw_q;
        out_q.orient_x     <= held_quat_q[0];
        out_q.orient_y     <= held_quat_q[1];
        out_q.orient_z     <= held_quat_q[2];
        out_q.orient_w     <= held_quat_q[3];
      end
      ppdr_pkg::OP_SQ_ACC: sum_q <= sum_q + 33'(sq_out);
      ppdr_pkg::OP_SQRT_INIT: begin
        v_q    <= {1'b0, sum_q, 28'b0};
        rem_q  <= '0;
        root_q <= '0;
      end
      ppdr_pkg::OP_SQRT_STEP: begin
        v_q <= {v_q[59:0], 2'b00};
        if (remx >= 35'(trial)) begin
          rem_q  <= 33'(remx - 35'(trial));
          root_q <= {root_q[29:0], 1'b1};
        end else begin
          rem_q  <= remx[32:0];
          root_q <= {root_q[29:0], 1'b0};
        end
      end
      ppdr_pkg::OP_DIV_INIT: begin
        for (int k = 0; k < 4; k++) begin
          drem_q[k] <= 32'(qnum[k][43:DB]);
          dnum_q[k] <= qnum[k][DB-1:0];
          dquo_q[k] <= '0;
        end
      end
      ppdr_pkg::OP_DIV_STEP: begin
        for (int k = 0; k < 4; k++) begin
          dnum_q[k] <= {dnum_q[k][DB-2:0], 1'b0};
          if (dr[k] >= 33'(root_q)) begin
            drem_q[k] <= 32'(dr[k] - 33'(root_q));
            dquo_q[k] <= {dquo_q[k][DB-2:0], 1'b1};
          end else begin
            drem_q[k] <= dr[k][31:0];
            dquo_q[k] <= {dquo_q[k][DB-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  assign status_o.req_type = in_i.req_type;
  assign status_o.el_zero  = (in_i.elapsed == '0);
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

// ===== sv/planar_pose_dead_reckoning.sv =====
// Tick item: the result follows the heading update, the iterative CORDIC and the
//   x and y updates through the two-pass shared 36x33 multiplier; the next
//   item is taken once the result is published and any waiting result accepted.
// IMU item: busy for 4 squares, 31 root bits and 16 quotient bits;
//   encoder items and skipped ticks do not leave idle. One item in flight at a time.
// Reset: pose and rates cleared, quaternion set to identity, no result pending.
`default_nettype none
module planar_pose_dead_reckoning #(
  parameter int CORDIC_STEPS  = 16,
  parameter int POS_FRAC_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  ppdr_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ppdr_pkg::out_item_t out_o
);

  ppdr_pkg::dp_cmd_t    cmd;
  ppdr_pkg::dp_status_t status;

  ppdr_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ppdr_dp #(
    .POS_FRAC_BITS(POS_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // a nonzero tick keeps the block busy
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_i.req_type == ppdr_pkg::REQ_TICK &&
     in_i.elapsed != '0) |=> !in_ready_o)
    else $error("tick item did not start integration");

  a_imu_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_i.req_type == ppdr_pkg::REQ_IMU) |=> !in_ready_o)
    else $error("imu item did not start normalization");

  // results only come out of the integration sequence
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  a_no_result_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_i.req_type == ppdr_pkg::REQ_ENC) |=> in_ready_o)
    else $error("encoder item left block busy");

endmodule
`default_nettype wire
